@@ rtl/lcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_pkg: shared constants for the line and circle rasterizer
// Canvas size, field widths, command codes and the canvas bounds check.
// ----------------------------------------------------------------------------
package lcr_pkg;

    localparam int CANVAS_WIDTH  = 128;
    localparam int CANVAS_HEIGHT = 64;

    localparam int CMD_W    = 3;
    localparam int COORD_W  = 11;
    localparam int RADIUS_W = 10;

    // Plot coordinates: centre plus or minus an offset needs one more bit.
    localparam int PT_W    = COORD_W + 1;
    localparam int DELTA_W = COORD_W + 1;
    localparam int ERR_W   = COORD_W + 4;
    localparam int DEC_W   = 16;

    localparam int ROW_AW = (CANVAS_HEIGHT > 1) ? $clog2(CANVAS_HEIGHT) : 1;
    localparam int COL_W  = (CANVAS_WIDTH > 1) ? $clog2(CANVAS_WIDTH) : 1;

    localparam logic signed [PT_W-1:0] X_LIM = PT_W'(CANVAS_WIDTH);
    localparam logic signed [PT_W-1:0] Y_LIM = PT_W'(CANVAS_HEIGHT);
    localparam logic [ROW_AW-1:0]      LAST_ROW = ROW_AW'(CANVAS_HEIGHT - 1);

    localparam logic [CMD_W-1:0] CMD_CLEAR  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_LINE   = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_RECT   = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_TRI    = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_CIRCLE = CMD_W'(4);
    localparam logic [CMD_W-1:0] CMD_READ   = CMD_W'(5);

    function automatic logic on_canvas(input logic signed [PT_W-1:0] px,
                                       input logic signed [PT_W-1:0] py);
        on_canvas = !px[PT_W-1] && (px < X_LIM) && !py[PT_W-1] && (py < Y_LIM);
    endfunction

endpackage

@@ rtl/lcr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered (old data on collision).
// ----------------------------------------------------------------------------
module lcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/line_circle_rasterizer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_circle_rasterizer_unit: one-bit canvas with line and circle drawing
// Bresenham lines, rectangles, triangles, midpoint circles, clear and read.
// ----------------------------------------------------------------------------
// Usage:
//   Drive command and the coordinate ports and raise start; the word is taken
//   at a clock edge where start is high and busy is low. Each command gives
//   one result word: done pulses for one cycle with pixel_read, which is the
//   pixel for a read command and 0 otherwise. The receiver cannot stall.
//   The canvas is a RAM of CANVAS_HEIGHT rows, each CANVAS_WIDTH bits wide.
//   Plots go through a read-modify-write pipeline of the row memory, one
//   pixel per cycle, with the last write forwarded to the next merge.
//   Line shapes set up each segment, then step along it pixel by pixel; a
//   circle walks the eight octant points of each midpoint step; clear wipes
//   one row per cycle; a read looks up the row and then returns the bit; an
//   unused code returns a word without drawing anything.
//   After reset the block runs a clearing pass over every row with busy
//   high and no result word.
// ----------------------------------------------------------------------------
module line_circle_rasterizer_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [lcr_pkg::CMD_W-1:0]            command,
    input  logic signed [lcr_pkg::COORD_W-1:0]   x_first,
    input  logic signed [lcr_pkg::COORD_W-1:0]   y_first,
    input  logic signed [lcr_pkg::COORD_W-1:0]   x_second,
    input  logic signed [lcr_pkg::COORD_W-1:0]   y_second,
    input  logic signed [lcr_pkg::COORD_W-1:0]   x_third,
    input  logic signed [lcr_pkg::COORD_W-1:0]   y_third,
    input  logic [lcr_pkg::RADIUS_W-1:0]         radius,
    output logic                                 done,
    output logic                                 pixel_read
);

    import lcr_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_CLEAR     = 8'b0000_0010,
        S_SEG_SETUP = 8'b0000_0100,
        S_LINE      = 8'b0000_1000,
        S_CIRCLE    = 8'b0001_0000,
        S_READ      = 8'b0010_0000,
        S_READ_WAIT = 8'b0100_0000,
        S_DRAIN     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   init_reg, init_next;
    logic   done_reg, done_next;
    logic   pixel_reg, pixel_next;

    logic [CMD_W-1:0]          cmd_reg, cmd_next;
    logic signed [COORD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic signed [COORD_W-1:0] x1_next, y1_next, x2_next, y2_next, x3_next, y3_next;

    logic [ROW_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic              rd_ok_reg, rd_ok_next;

    // line walker
    logic [1:0]                seg_reg, seg_next;
    logic signed [COORD_W-1:0] la_x_reg, la_y_reg, lb_x_reg, lb_y_reg;
    logic signed [COORD_W-1:0] la_x_next, la_y_next, lb_x_next, lb_y_next;
    logic signed [DELTA_W-1:0] ldx_reg, ldy_reg, ldx_next, ldy_next;
    logic                      lsx_reg, lsy_reg, lsx_next, lsy_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;

    // circle walker
    logic signed [PT_W-1:0]  cir_x_reg, cir_y_reg, cir_x_next, cir_y_next;
    logic signed [DEC_W-1:0] dec_reg, dec_next;
    logic [2:0]              oct_reg, oct_next;

    // plot pipeline
    logic                    p1_valid_reg;
    logic [ROW_AW-1:0]       p1_row_reg;
    logic [COL_W-1:0]        p1_col_reg;
    logic                    fwd_valid_reg;
    logic [ROW_AW-1:0]       fwd_row_reg;
    logic [CANVAS_WIDTH-1:0] fwd_data_reg;

    // segment endpoints
    logic signed [COORD_W-1:0] sa_x, sa_y, sb_x, sb_y;
    logic                      last_seg;
    logic signed [DELTA_W-1:0] sa_x_e, sa_y_e, sb_x_e, sb_y_e, dx_s, dy_s;

    // line step
    logic signed [ERR_W:0]     e2, ldx_e, ldy_e;
    logic                      step_x, step_y, at_end;
    logic [COORD_W-1:0]        inc_x, inc_y;

    // circle plot point
    logic signed [PT_W-1:0]    u_off, v_off, cx_e, cy_e, cpx, cpy;
    logic                      cir_end;

    // generated plot
    logic                      gen_valid;
    logic signed [PT_W-1:0]    gpx, gpy;

    // memory
    logic                      ram_we;
    logic [ROW_AW-1:0]         ram_waddr, ram_raddr;
    logic [CANVAS_WIDTH-1:0]   ram_wdata, ram_rdata, merge_base, bit_mask;

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign pixel_read = pixel_reg;

    always_comb
    begin
        sa_x     = x1_reg;
        sa_y     = y1_reg;
        sb_x     = x2_reg;
        sb_y     = y2_reg;
        last_seg = 1'b1;
        case (cmd_reg)
            CMD_RECT:
            begin
                last_seg = (seg_reg == 2'd3);
                case (seg_reg)
                    2'd0:
                    begin
                        sa_x = x1_reg; sa_y = y1_reg; sb_x = x2_reg; sb_y = y1_reg;
                    end
                    2'd1:
                    begin
                        sa_x = x2_reg; sa_y = y1_reg; sb_x = x2_reg; sb_y = y2_reg;
                    end
                    2'd2:
                    begin
                        sa_x = x2_reg; sa_y = y2_reg; sb_x = x1_reg; sb_y = y2_reg;
                    end
                    default:
                    begin
                        sa_x = x1_reg; sa_y = y2_reg; sb_x = x1_reg; sb_y = y1_reg;
                    end
                endcase
            end
            CMD_TRI:
            begin
                last_seg = (seg_reg == 2'd2);
                case (seg_reg)
                    2'd0:
                    begin
                        sa_x = x1_reg; sa_y = y1_reg; sb_x = x2_reg; sb_y = y2_reg;
                    end
                    2'd1:
                    begin
                        sa_x = x2_reg; sa_y = y2_reg; sb_x = x3_reg; sb_y = y3_reg;
                    end
                    default:
                    begin
                        sa_x = x3_reg; sa_y = y3_reg; sb_x = x1_reg; sb_y = y1_reg;
                    end
                endcase
            end
            default:
            begin
                last_seg = 1'b1;
            end
        endcase
    end

    assign sa_x_e = DELTA_W'(sa_x);
    assign sa_y_e = DELTA_W'(sa_y);
    assign sb_x_e = DELTA_W'(sb_x);
    assign sb_y_e = DELTA_W'(sb_y);
    assign dx_s   = (sb_x_e > sa_x_e) ? (sb_x_e - sa_x_e) : (sa_x_e - sb_x_e);
    assign dy_s   = (sb_y_e > sa_y_e) ? (sb_y_e - sa_y_e) : (sa_y_e - sb_y_e);

    assign e2     = $signed({err_reg, 1'b0});
    assign ldx_e  = (ERR_W + 1)'(ldx_reg);
    assign ldy_e  = (ERR_W + 1)'(ldy_reg);
    assign step_x = (e2 > -ldy_e);
    assign step_y = (e2 < ldx_e);
    assign at_end = (la_x_reg == lb_x_reg) && (la_y_reg == lb_y_reg);
    assign inc_x  = lsx_reg ? {COORD_W{1'b1}} : COORD_W'(1);
    assign inc_y  = lsy_reg ? {COORD_W{1'b1}} : COORD_W'(1);

    assign u_off   = oct_reg[2] ? cir_y_reg : cir_x_reg;
    assign v_off   = oct_reg[2] ? cir_x_reg : cir_y_reg;
    assign cx_e    = PT_W'(x1_reg);
    assign cy_e    = PT_W'(y1_reg);
    assign cpx     = oct_reg[0] ? (cx_e - u_off) : (cx_e + u_off);
    assign cpy     = oct_reg[1] ? (cy_e - v_off) : (cy_e + v_off);
    assign cir_end = (oct_reg == 3'd0) && (cir_x_reg > cir_y_reg);

    always_comb
    begin
        gpx = PT_W'(la_x_reg);
        gpy = PT_W'(la_y_reg);
        if (state_reg == S_CIRCLE)
        begin
            gpx = cpx;
            gpy = cpy;
        end
    end

    assign gen_valid = ((state_reg == S_LINE) || ((state_reg == S_CIRCLE) && !cir_end))
                       && on_canvas(gpx, gpy);

    always_comb
    begin
        state_next   = state_reg;
        init_next    = init_reg;
        done_next    = 1'b0;
        pixel_next   = 1'b0;
        cmd_next     = cmd_reg;
        x1_next      = x1_reg;
        y1_next      = y1_reg;
        x2_next      = x2_reg;
        y2_next      = y2_reg;
        x3_next      = x3_reg;
        y3_next      = y3_reg;
        clr_cnt_next = clr_cnt_reg;
        rd_ok_next   = rd_ok_reg;
        seg_next     = seg_reg;
        la_x_next    = la_x_reg;
        la_y_next    = la_y_reg;
        lb_x_next    = lb_x_reg;
        lb_y_next    = lb_y_reg;
        ldx_next     = ldx_reg;
        ldy_next     = ldy_reg;
        lsx_next     = lsx_reg;
        lsy_next     = lsy_reg;
        err_next     = err_reg;
        cir_x_next   = cir_x_reg;
        cir_y_next   = cir_y_reg;
        dec_next     = dec_reg;
        oct_next     = oct_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    x1_next  = x_first;
                    y1_next  = y_first;
                    x2_next  = x_second;
                    y2_next  = y_second;
                    x3_next  = x_third;
                    y3_next  = y_third;
                    seg_next = 2'd0;
                    case (command)
                        CMD_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        CMD_LINE, CMD_RECT, CMD_TRI:
                        begin
                            state_next = S_SEG_SETUP;
                        end
                        CMD_CIRCLE:
                        begin
                            cir_x_next = '0;
                            cir_y_next = PT_W'(radius);
                            dec_next   = DEC_W'(1 - $signed({1'b0, radius}));
                            oct_next   = 3'd0;
                            state_next = S_CIRCLE;
                        end
                        CMD_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DRAIN;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ROW)
                begin
                    init_next  = 1'b0;
                    state_next = init_reg ? S_IDLE : S_DRAIN;
                end
            end
            S_SEG_SETUP:
            begin
                la_x_next  = sa_x;
                la_y_next  = sa_y;
                lb_x_next  = sb_x;
                lb_y_next  = sb_y;
                ldx_next   = dx_s;
                ldy_next   = dy_s;
                lsx_next   = !(sa_x < sb_x);
                lsy_next   = !(sa_y < sb_y);
                err_next   = ERR_W'(dx_s) - ERR_W'(dy_s);
                state_next = S_LINE;
            end
            S_LINE:
            begin
                if (at_end)
                begin
                    seg_next   = seg_reg + 2'd1;
                    state_next = last_seg ? S_DRAIN : S_SEG_SETUP;
                end
                else
                begin
                    err_next = err_reg - (step_x ? ERR_W'(ldy_reg) : '0)
                                       + (step_y ? ERR_W'(ldx_reg) : '0);
                    if (step_x)
                    begin
                        la_x_next = la_x_reg + inc_x;
                    end
                    if (step_y)
                    begin
                        la_y_next = la_y_reg + inc_y;
                    end
                end
            end
            S_CIRCLE:
            begin
                if (cir_end)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    oct_next = oct_reg + 3'd1;
                    if (oct_reg == 3'd7)
                    begin
                        cir_x_next = cir_x_reg + 1'b1;
                        if (dec_reg[DEC_W-1])
                        begin
                            dec_next = dec_reg + DEC_W'(2 * cir_x_reg + 3);
                        end
                        else
                        begin
                            dec_next   = dec_reg + DEC_W'(2 * (cir_x_reg - cir_y_reg) + 5);
                            cir_y_next = cir_y_reg - 1'b1;
                        end
                    end
                end
            end
            S_READ:
            begin
                rd_ok_next = on_canvas(PT_W'(x1_reg), PT_W'(y1_reg));
                state_next = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                done_next  = 1'b1;
                pixel_next = rd_ok_reg && ram_rdata[x1_reg[COL_W-1:0]];
                state_next = S_IDLE;
            end
            S_DRAIN:
            begin
                // hold until the last plot has been written back
                if (!p1_valid_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // read-modify-write of one canvas row
    assign merge_base = (fwd_valid_reg && (fwd_row_reg == p1_row_reg)) ? fwd_data_reg
                                                                        : ram_rdata;
    assign bit_mask   = {{(CANVAS_WIDTH - 1){1'b0}}, 1'b1} << p1_col_reg;

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = p1_valid_reg;
            ram_waddr = p1_row_reg;
            ram_wdata = merge_base | bit_mask;
        end
    end

    assign ram_raddr = (state_reg == S_READ) ? y1_reg[ROW_AW-1:0] : gpy[ROW_AW-1:0];

    lcr_ram #(
        .WIDTH (CANVAS_WIDTH),
        .DEPTH (CANVAS_HEIGHT)
    ) u_canvas (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            init_reg      <= 1'b1;
            clr_cnt_reg   <= '0;
            done_reg      <= 1'b0;
            pixel_reg     <= 1'b0;
            p1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            clr_cnt_reg   <= clr_cnt_next;
            done_reg      <= done_next;
            pixel_reg     <= pixel_next;
            p1_valid_reg  <= gen_valid;
            fwd_valid_reg <= p1_valid_reg && (state_reg != S_CLEAR);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        x1_reg     <= x1_next;
        y1_reg     <= y1_next;
        x2_reg     <= x2_next;
        y2_reg     <= y2_next;
        x3_reg     <= x3_next;
        y3_reg     <= y3_next;
        rd_ok_reg  <= rd_ok_next;
        seg_reg    <= seg_next;
        la_x_reg   <= la_x_next;
        la_y_reg   <= la_y_next;
        lb_x_reg   <= lb_x_next;
        lb_y_reg   <= lb_y_next;
        ldx_reg    <= ldx_next;
        ldy_reg    <= ldy_next;
        lsx_reg    <= lsx_next;
        lsy_reg    <= lsy_next;
        err_reg    <= err_next;
        cir_x_reg  <= cir_x_next;
        cir_y_reg  <= cir_y_next;
        dec_reg    <= dec_next;
        oct_reg    <= oct_next;
        p1_row_reg <= gpy[ROW_AW-1:0];
        p1_col_reg <= gpx[COL_W-1:0];
        if (p1_valid_reg)
        begin
            fwd_row_reg  <= p1_row_reg;
            fwd_data_reg <= ram_wdata;
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    a_pixel_done: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_read |-> done)
        else $error("pixel_read high without done");

    a_clear_no_plot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !p1_valid_reg)
        else $error("plot write during clear sweep");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command taken without going busy");

endmodule

@@ tb/lcr_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_tb_pkg: canvas scoreboard for the line and circle rasterizer bench
// Keeps a shadow canvas, redraws every accepted command on it and queues the
// pixel_read word that the command must return, then checks returned words
// in order against that queue.
// ----------------------------------------------------------------------------
package lcr_tb_pkg;

    localparam logic [lcr_pkg::CMD_W-1:0] CMD_RESERVED_A = lcr_pkg::CMD_W'(6);
    localparam logic [lcr_pkg::CMD_W-1:0] CMD_RESERVED_B = lcr_pkg::CMD_W'(7);

    localparam int REPORT_LIMIT = 10;

    class canvas_scoreboard;

        bit canvas_bits [lcr_pkg::CANVAS_HEIGHT][lcr_pkg::CANVAS_WIDTH];
        bit expected_pixels [$];
        int error_count;

        function new();
            wipe_canvas();
            error_count = 0;
        endfunction

        function void wipe_canvas();
            foreach (canvas_bits[row, col])
                canvas_bits[row][col] = 1'b0;
        endfunction

        function void set_dot(int px, int py);
            if (px >= 0 && px < lcr_pkg::CANVAS_WIDTH && py >= 0 && py < lcr_pkg::CANVAS_HEIGHT)
                canvas_bits[py][px] = 1'b1;
        endfunction

        function void draw_segment(int xa, int ya, int xb, int yb);
            int dx;
            int dy;
            int sx;
            int sy;
            int err;
            int e2;
            dx = (xb > xa) ? xb - xa : xa - xb;
            dy = (yb > ya) ? yb - ya : ya - yb;
            sx = (xa < xb) ? 1 : -1;
            sy = (ya < yb) ? 1 : -1;
            err = dx - dy;
            forever
            begin
                set_dot(xa, ya);
                if (xa == xb && ya == yb)
                    break;
                e2 = 2 * err;
                if (e2 > -dy)
                begin
                    err -= dy;
                    xa += sx;
                end
                if (e2 < dx)
                begin
                    err += dx;
                    ya += sy;
                end
            end
        endfunction

        function void note_error(string msg);
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("ERROR at %0t: %s", $time, msg);
        endfunction

        // Redraw one accepted command and queue its pixel_read word.
        function void record_command(logic [lcr_pkg::CMD_W-1:0] cmd,
                                     logic signed [lcr_pkg::COORD_W-1:0] xa,
                                     logic signed [lcr_pkg::COORD_W-1:0] ya,
                                     logic signed [lcr_pkg::COORD_W-1:0] xb,
                                     logic signed [lcr_pkg::COORD_W-1:0] yb,
                                     logic signed [lcr_pkg::COORD_W-1:0] xc,
                                     logic signed [lcr_pkg::COORD_W-1:0] yc,
                                     logic [lcr_pkg::RADIUS_W-1:0] rad);
            int x1;
            int y1;
            int x2;
            int y2;
            int x3;
            int y3;
            int px;
            int py;
            int d;
            bit word;
            x1 = xa;
            y1 = ya;
            x2 = xb;
            y2 = yb;
            x3 = xc;
            y3 = yc;
            word = 1'b0;
            case (cmd)
                lcr_pkg::CMD_CLEAR:
                    wipe_canvas();
                lcr_pkg::CMD_LINE:
                    draw_segment(x1, y1, x2, y2);
                lcr_pkg::CMD_RECT:
                begin
                    draw_segment(x1, y1, x2, y1);
                    draw_segment(x2, y1, x2, y2);
                    draw_segment(x2, y2, x1, y2);
                    draw_segment(x1, y2, x1, y1);
                end
                lcr_pkg::CMD_TRI:
                begin
                    draw_segment(x1, y1, x2, y2);
                    draw_segment(x2, y2, x3, y3);
                    draw_segment(x3, y3, x1, y1);
                end
                lcr_pkg::CMD_CIRCLE:
                begin
                    px = 0;
                    py = int'(rad);
                    d = 1 - py;
                    while (px <= py)
                    begin
                        set_dot(x1 + px, y1 + py);
                        set_dot(x1 - px, y1 + py);
                        set_dot(x1 + px, y1 - py);
                        set_dot(x1 - px, y1 - py);
                        set_dot(x1 + py, y1 + px);
                        set_dot(x1 - py, y1 + px);
                        set_dot(x1 + py, y1 - px);
                        set_dot(x1 - py, y1 - px);
                        if (d < 0)
                            d += 2 * px + 3;
                        else
                        begin
                            d += 2 * (px - py) + 5;
                            py--;
                        end
                        px++;
                    end
                end
                lcr_pkg::CMD_READ:
                    if (x1 >= 0 && x1 < lcr_pkg::CANVAS_WIDTH &&
                        y1 >= 0 && y1 < lcr_pkg::CANVAS_HEIGHT)
                        word = canvas_bits[y1][x1];
                default:
                    word = 1'b0;
            endcase
            expected_pixels.push_back(word);
        endfunction

        function void check_pixel_word(logic actual);
            bit want;
            if (expected_pixels.size() == 0)
            begin
                note_error($sformatf("result word with none expected, pixel_read %0b", actual));
                return;
            end
            want = expected_pixels.pop_front();
            if (actual !== want)
                note_error($sformatf("pixel_read expected %0b got %0b", want, actual));
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

    endclass

endpackage

@@ tb/tb_line_circle_rasterizer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_circle_rasterizer_unit: self-checking bench for the rasterizer
// Directed draws and reads at the field extremes, then random shapes and
// reads aimed at drawn pixels, under several sender idle rates. Every
// returned word is checked against a shadow canvas in the scoreboard.
// ----------------------------------------------------------------------------
module tb_line_circle_rasterizer_unit;

    import lcr_tb_pkg::*;

    localparam int RANDOM_WORDS   = 1900;
    localparam int PHASES         = 4;
    localparam int IDLE_PCT [PHASES] = '{0, 86, 34, 0};
    localparam int MAX_GAP        = 40;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 100;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic [lcr_pkg::CMD_W-1:0]            command;
    logic signed [lcr_pkg::COORD_W-1:0]   x_first;
    logic signed [lcr_pkg::COORD_W-1:0]   y_first;
    logic signed [lcr_pkg::COORD_W-1:0]   x_second;
    logic signed [lcr_pkg::COORD_W-1:0]   y_second;
    logic signed [lcr_pkg::COORD_W-1:0]   x_third;
    logic signed [lcr_pkg::COORD_W-1:0]   y_third;
    logic [lcr_pkg::RADIUS_W-1:0]         radius;
    logic                                 done;
    logic                                 pixel_read;

    canvas_scoreboard sb;
    int idle_cycles = 0;
    int hot_x = 0;
    int hot_y = 0;

    line_circle_rasterizer_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .x_first    (x_first),
        .y_first    (y_first),
        .x_second   (x_second),
        .y_second   (y_second),
        .x_third    (x_third),
        .y_third    (y_third),
        .radius     (radius),
        .done       (done),
        .pixel_read (pixel_read)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.record_command(command, x_first, y_first, x_second, y_second,
                                  x_third, y_third, radius);
            if (done)
                sb.check_pixel_word(pixel_read);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_word(logic [lcr_pkg::CMD_W-1:0] cmd, int xa, int ya, int xb, int yb,
                             int xc, int yc, int rad);
        @(negedge clk);
        start    <= 1'b1;
        command  <= cmd;
        x_first  <= lcr_pkg::COORD_W'(xa);
        y_first  <= lcr_pkg::COORD_W'(ya);
        x_second <= lcr_pkg::COORD_W'(xb);
        y_second <= lcr_pkg::COORD_W'(yb);
        x_third  <= lcr_pkg::COORD_W'(xc);
        y_third  <= lcr_pkg::COORD_W'(yc);
        radius   <= lcr_pkg::RADIUS_W'(rad);
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic sender_gap(int pct);
        int n;
        n = 0;
        while (n < MAX_GAP && int'($urandom_range(99)) < pct)
            n++;
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_x();
        if ($urandom_range(99) < 2)
            return int'($urandom_range(2047)) - 1024;
        return int'($urandom_range(159)) - 16;
    endfunction

    function automatic int pick_y();
        if ($urandom_range(99) < 2)
            return int'($urandom_range(2047)) - 1024;
        return int'($urandom_range(95)) - 16;
    endfunction

    task automatic random_word();
        int sel;
        int aim;
        int xa;
        int ya;
        int xb;
        int yb;
        int xc;
        int yc;
        int rad;
        logic [lcr_pkg::CMD_W-1:0] cmd;
        sel = int'($urandom_range(99));
        xa = pick_x();
        ya = pick_y();
        xb = pick_x();
        yb = pick_y();
        xc = pick_x();
        yc = pick_y();
        rad = int'($urandom_range(1023));
        if (sel < 35)
        begin
            cmd = lcr_pkg::CMD_READ;
            aim = int'($urandom_range(9));
            if (aim < 6)
            begin
                xa = hot_x + int'($urandom_range(2)) - 1;
                ya = hot_y + int'($urandom_range(2)) - 1;
            end
            else if (aim < 9)
            begin
                xa = int'($urandom_range(lcr_pkg::CANVAS_WIDTH - 1));
                ya = int'($urandom_range(lcr_pkg::CANVAS_HEIGHT - 1));
            end
            else
            begin
                xa = int'($urandom_range(2047)) - 1024;
                ya = int'($urandom_range(2047)) - 1024;
            end
        end
        else if (sel < 55)
        begin
            cmd = lcr_pkg::CMD_LINE;
            hot_x = xb;
            hot_y = yb;
        end
        else if (sel < 65)
        begin
            cmd = lcr_pkg::CMD_RECT;
            hot_x = xa;
            hot_y = yb;
        end
        else if (sel < 75)
        begin
            cmd = lcr_pkg::CMD_TRI;
            hot_x = xc;
            hot_y = yc;
        end
        else if (sel < 90)
        begin
            cmd = lcr_pkg::CMD_CIRCLE;
            aim = int'($urandom_range(99));
            if (aim < 90)
                rad = int'($urandom_range(40));
            else if (aim < 98)
                rad = int'($urandom_range(100, 41));
            hot_x = xa + rad;
            hot_y = ya;
        end
        else if (sel < 94)
            cmd = lcr_pkg::CMD_CLEAR;
        else if (sel < 97)
            cmd = $urandom_range(1) ? CMD_RESERVED_A : CMD_RESERVED_B;
        else
        begin
            cmd = lcr_pkg::CMD_LINE;
            xa = int'($urandom_range(2047)) - 1024;
            yb = int'($urandom_range(2047)) - 1024;
            hot_x = xb;
            hot_y = yb;
        end
        send_word(cmd, xa, ya, xb, yb, xc, yc, rad);
    endtask

    initial
    begin
        sb = new();
        rst_n    = 1'b0;
        start    = 1'b0;
        command  = lcr_pkg::CMD_CLEAR;
        x_first  = '0;
        y_first  = '0;
        x_second = '0;
        y_second = '0;
        x_third  = '0;
        y_third  = '0;
        radius   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(lcr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0);
        send_word(lcr_pkg::CMD_LINE, 0, 0, 127, 63, 0, 0, 0);
        send_word(lcr_pkg::CMD_READ, 127, 63, 0, 0, 0, 0, 0);
        send_word(lcr_pkg::CMD_LINE, 5, 5, 5, 5, 0, 0, 1023);
        send_word(lcr_pkg::CMD_READ, 5, 5, 0, 0, 0, 0, 0);
        send_word(lcr_pkg::CMD_LINE, -1024, -1024, 1023, 1023, 0, 0, 0);
        send_word(lcr_pkg::CMD_READ, 63, 63, 0, 0, 0, 0, 0);
        send_word(lcr_pkg::CMD_RECT, 10, 10, 30, 20, 0, 0, 0);
        send_word(lcr_pkg::CMD_READ, 10, 15, 0, 0, 0, 0, 0);
        send_word(lcr_pkg::CMD_RECT, -1024, 1023, 1023, -1024, 0, 0, 0);
        send_word(lcr_pkg::CMD_TRI, 100, 5, 120, 60, 70, 40, 0);
        send_word(lcr_pkg::CMD_READ, 120, 60, 0, 0, 0, 0, 0);
        send_word(lcr_pkg::CMD_TRI, 0, 63, -1024, 1023, 1023, -1024, 0);
        send_word(lcr_pkg::CMD_CIRCLE, 64, 32, 0, 0, 0, 0, 0);
        send_word(lcr_pkg::CMD_READ, 64, 32, 0, 0, 0, 0, 0);
        send_word(lcr_pkg::CMD_CIRCLE, 64, 32, 0, 0, 0, 0, 20);
        send_word(lcr_pkg::CMD_READ, 84, 32, 0, 0, 0, 0, 0);
        send_word(lcr_pkg::CMD_CIRCLE, -1024, -1024, 0, 0, 0, 0, 1023);
        send_word(lcr_pkg::CMD_READ, -1, 0, 0, 0, 0, 0, 0);
        send_word(lcr_pkg::CMD_READ, 128, 64, 0, 0, 0, 0, 0);
        send_word(CMD_RESERVED_A, 5, 5, 127, 63, 64, 32, 20);
        send_word(CMD_RESERVED_B, 1023, -1024, -1024, 1023, 1023, 1023, 512);
        send_word(lcr_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        send_word(lcr_pkg::CMD_READ, 5, 5, 0, 0, 0, 0, 0);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int k = 0; k < RANDOM_WORDS / PHASES; k++)
            begin
                random_word();
                sender_gap(IDLE_PCT[ph]);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
